// ===== sv/loose_pattern_line_classifier_macros.svh =====
// Assertion macros for the loose pattern line classifier.
`ifndef LOOSE_PATTERN_LINE_CLASSIFIER_MACROS_SVH
`define LOOSE_PATTERN_LINE_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define LPLC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lplc assertion failed");
// Check that a condition implies another in the next cycle.
`define LPLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lplc assertion failed");
`else
`define LPLC_ASSERT_SAME(label, ante, cons)
`define LPLC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/lplc_pkg.sv =====
// Shared constants and types for the loose pattern line classifier.
package lplc_pkg;

   localparam int DEPTH_BITS_DEFAULT  = 8;
   localparam int LENGTH_BITS_DEFAULT = 16;

   localparam int CHAR_BITS    = 8;
   localparam int TOKEN_BITS   = 16;
   localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = 16'hFFFF;

   // Character codes
   localparam logic [CHAR_BITS-1:0] CH_NUL      = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF       = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_CR       = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_DQUOTE   = 8'h22;
   localparam logic [CHAR_BITS-1:0] CH_SQUOTE   = 8'h27;
   localparam logic [CHAR_BITS-1:0] CH_LPAREN   = 8'h28;
   localparam logic [CHAR_BITS-1:0] CH_RPAREN   = 8'h29;
   localparam logic [CHAR_BITS-1:0] CH_COMMA    = 8'h2C;
   localparam logic [CHAR_BITS-1:0] CH_SEMI     = 8'h3B;
   localparam logic [CHAR_BITS-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [CHAR_BITS-1:0] CH_BSLASH   = 8'h5C;
   localparam logic [CHAR_BITS-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [CHAR_BITS-1:0] CH_LBRACE   = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE   = 8'h7D;

   // Per-character outcome of the scanner
   typedef struct packed {
      logic                  line_end;
      logic                  emit_text;
      logic [TOKEN_BITS-1:0] token_length;
   } scan_result_type;

endpackage

// ===== sv/lplc_channels.sv =====
// Request and response channel interfaces for the loose pattern line classifier.
interface lplc_req_if;
   logic                             valid;
   logic                             ready;
   logic [lplc_pkg::CHAR_BITS-1:0]   ch;
   logic                             end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface lplc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             emit_text;
   logic [lplc_pkg::TOKEN_BITS-1:0]  token_length;

   modport source (output valid, output emit_text, output token_length, input ready);
   modport sink   (input valid, input emit_text, input token_length, output ready);
endinterface

// ===== sv/loose_pattern_line_classifier.sv =====
// An accepted request is held in the request stage; at a line end its result loads the response register.
// Throughput: one character per cycle while the response side does not stall; the line state
// update is a single pass of small counters between the request stage and the response register.
// Only characters that end a line (newline, NUL, end flag) produce a response;
// a response the receiver has not taken stalls the request side until it is taken.
// Reset is synchronous, active high, and clears all line state; no clearing pass.
`include "loose_pattern_line_classifier_macros.svh"

module loose_pattern_line_classifier #(
   parameter int DEPTH_BITS  = lplc_pkg::DEPTH_BITS_DEFAULT,
   parameter int LENGTH_BITS = lplc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lplc_req_if.sink    req_bus,
   lplc_rsp_if.source  rsp_bus
);

   logic                                stg_valid_ff, stg_valid_in;
   logic [lplc_pkg::CHAR_BITS-1:0]      stg_ch_ff;
   logic                                stg_eoi_ff;
   logic                                out_valid_ff, out_valid_in;
   logic                                out_emit_ff;
   logic [lplc_pkg::TOKEN_BITS-1:0]     out_length_ff;
   logic                                stage_go;
   logic                                req_take;
   lplc_pkg::scan_result_type           scan_result;

   // Advance the request stage when the response register can take a result
   assign stage_go      = stg_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stg_valid_ff || stage_go;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign stg_valid_in = req_take || (stg_valid_ff && !stage_go);
   assign out_valid_in = (stage_go && scan_result.line_end) ||
                         (out_valid_ff && !rsp_bus.ready);

   lplc_scanner #(
      .DEPTH_BITS  (DEPTH_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scanner (
      .clock        (clock),
      .reset        (reset),
      .step         (stage_go),
      .ch           (stg_ch_ff),
      .end_of_input (stg_eoi_ff),
      .result       (scan_result)
   );

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      if (req_take) begin
         stg_ch_ff  <= req_bus.ch;
         stg_eoi_ff <= req_bus.end_of_input;
      end
   end

   // Load the response register at each line end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (stage_go && scan_result.line_end) begin
         out_emit_ff   <= scan_result.emit_text;
         out_length_ff <= scan_result.token_length;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.emit_text    = out_emit_ff;
   assign rsp_bus.token_length = out_length_ff;

   // Checks
   `LPLC_ASSERT_NEXT(a_stage_holds, stg_valid_ff && !stage_go, stg_valid_ff)
   `LPLC_ASSERT_NEXT(a_line_end_responds, stage_go && scan_result.line_end, out_valid_ff)
   `LPLC_ASSERT_SAME(a_plain_line_zero_len, out_valid_ff && !out_emit_ff, out_length_ff == '0)
   `LPLC_ASSERT_SAME(a_step_needs_room, stage_go, !out_valid_ff || rsp_bus.ready)

endmodule

// ===== sv/lplc_scanner.sv =====
// Line scanner: per-line state and the one-character update of that state.
module lplc_scanner #(
   parameter int DEPTH_BITS  = lplc_pkg::DEPTH_BITS_DEFAULT,
   parameter int LENGTH_BITS = lplc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [lplc_pkg::CHAR_BITS-1:0]   ch,
   input  logic                             end_of_input,
   output lplc_pkg::scan_result_type        result
);

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_SCAN,
      PH_SCAN_BS,
      PH_STR,
      PH_STR_QUOTE,
      PH_TAIL,
      PH_TAIL_BS,
      PH_WAIT
   } phase_type;

   localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] POS_MAX   = {LENGTH_BITS{1'b1}};

   phase_type               phase_ff, phase_in;
   logic [DEPTH_BITS-1:0]   paren_ff, paren_in;
   logic [DEPTH_BITS-1:0]   bracket_ff, bracket_in;
   logic [DEPTH_BITS-1:0]   brace_ff, brace_in;
   logic                    loose_ff, loose_in;
   logic                    decided_ff, decided_in;
   logic                    qdbl_ff, qdbl_in;
   logic                    bs_cr_ff, bs_cr_in;
   logic [LENGTH_BITS-1:0]  pos_ff, pos_in;
   logic [LENGTH_BITS-1:0]  mark_ff, mark_in;

   logic [LENGTH_BITS-1:0]  pos_inc;
   logic [LENGTH_BITS-1:0]  mark_eff;
   logic [LENGTH_BITS-1:0]  len_raw;
   logic [lplc_pkg::CHAR_BITS-1:0] quote;
   logic                    is_blank;
   logic                    line_end;
   logic                    run_scan;
   logic                    run_tail;
   logic                    go_tail;

   assign pos_inc  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign quote    = qdbl_ff ? lplc_pkg::CH_DQUOTE : lplc_pkg::CH_SQUOTE;
   assign is_blank = (ch == lplc_pkg::CH_SPACE) || (ch == lplc_pkg::CH_TAB);
   assign line_end = end_of_input || (ch == lplc_pkg::CH_NUL) ||
                     ((ch == lplc_pkg::CH_LF) && (phase_ff != PH_SCAN_BS) &&
                      (phase_ff != PH_TAIL_BS));

   // Build the verdict for a line end
   assign mark_eff = (phase_ff == PH_TAIL_BS) ? pos_ff : mark_ff;
   assign len_raw  = decided_ff ? mark_eff : pos_ff;

   always_comb begin
      result.line_end  = step && line_end;
      result.emit_text = (phase_ff != PH_SKIP) && (phase_ff != PH_WAIT) &&
                         (loose_ff || (paren_ff != '0) || (bracket_ff != '0) ||
                          (brace_ff != '0));
      if (!result.emit_text) begin
         result.token_length = '0;
      end else if (len_raw > LENGTH_BITS'(lplc_pkg::TOKEN_MAX)) begin
         result.token_length = lplc_pkg::TOKEN_MAX;
      end else begin
         result.token_length = lplc_pkg::TOKEN_BITS'(len_raw);
      end
   end

   // Work out the next line state for one character
   always_comb begin
      phase_in   = phase_ff;
      paren_in   = paren_ff;
      bracket_in = bracket_ff;
      brace_in   = brace_ff;
      loose_in   = loose_ff;
      decided_in = decided_ff;
      qdbl_in    = qdbl_ff;
      bs_cr_in   = bs_cr_ff;
      pos_in     = pos_ff;
      mark_in    = mark_ff;
      run_scan   = 1'b0;
      run_tail   = 1'b0;
      go_tail    = 1'b0;

      if (line_end) begin
         phase_in   = PH_SKIP;
         paren_in   = '0;
         bracket_in = '0;
         brace_in   = '0;
         loose_in   = 1'b0;
         decided_in = 1'b0;
         qdbl_in    = 1'b0;
         bs_cr_in   = 1'b0;
         pos_in     = '0;
         mark_in    = '0;
      end else if (ch == lplc_pkg::CH_LF) begin
         // continued line: newline after a backslash
         pos_in = pos_inc;
         if (phase_ff == PH_SCAN_BS) begin
            phase_in = PH_SCAN;
         end else begin
            phase_in = PH_TAIL;
         end
      end else begin
         case (phase_ff)
            PH_SKIP: begin
               if (is_blank) begin
                  pos_in = pos_inc;
               end else if (ch == lplc_pkg::CH_CR) begin
                  phase_in = PH_WAIT;
               end else begin
                  if ((ch == lplc_pkg::CH_COMMA) || (ch == lplc_pkg::CH_RPAREN) ||
                      (ch == lplc_pkg::CH_RBRACKET) || (ch == lplc_pkg::CH_RBRACE) ||
                      (ch == lplc_pkg::CH_SEMI)) begin
                     loose_in = 1'b1;
                  end
                  run_scan = 1'b1;
               end
            end
            PH_SCAN: begin
               run_scan = 1'b1;
            end
            PH_SCAN_BS, PH_TAIL_BS: begin
               if (!bs_cr_ff && is_blank) begin
                  pos_in = pos_inc;
               end else if (!bs_cr_ff && (ch == lplc_pkg::CH_CR)) begin
                  pos_in   = pos_inc;
                  bs_cr_in = 1'b1;
               end else if (phase_ff == PH_SCAN_BS) begin
                  run_scan = 1'b1;
               end else begin
                  mark_in  = pos_ff;
                  run_tail = 1'b1;
               end
            end
            PH_STR: begin
               if (ch == quote) begin
                  pos_in   = pos_inc;
                  phase_in = PH_STR_QUOTE;
               end else if (ch == lplc_pkg::CH_CR) begin
                  run_scan = 1'b1;
               end else begin
                  pos_in = pos_inc;
               end
            end
            PH_STR_QUOTE: begin
               if (ch == quote) begin
                  pos_in   = pos_inc;
                  phase_in = PH_STR;
               end else begin
                  run_scan = 1'b1;
               end
            end
            PH_TAIL: begin
               run_tail = 1'b1;
            end
            default: begin
               // waiting for the line end after a leading CR
            end
         endcase
      end

      // Scan one structural character
      if (run_scan) begin
         phase_in = PH_SCAN;
         pos_in   = pos_inc;
         case (ch)
            lplc_pkg::CH_BSLASH: begin
               phase_in = PH_SCAN_BS;
               bs_cr_in = 1'b0;
            end
            lplc_pkg::CH_LPAREN: begin
               paren_in = (paren_ff == DEPTH_MAX) ? paren_ff : paren_ff + 1'b1;
            end
            lplc_pkg::CH_LBRACKET: begin
               bracket_in = (bracket_ff == DEPTH_MAX) ? bracket_ff : bracket_ff + 1'b1;
            end
            lplc_pkg::CH_LBRACE: begin
               brace_in = (brace_ff == DEPTH_MAX) ? brace_ff : brace_ff + 1'b1;
            end
            lplc_pkg::CH_RPAREN: begin
               if (paren_ff == '0) begin
                  go_tail = 1'b1;
               end else begin
                  paren_in = paren_ff - 1'b1;
               end
            end
            lplc_pkg::CH_RBRACKET: begin
               if (bracket_ff == '0) begin
                  go_tail = 1'b1;
               end else begin
                  bracket_in = bracket_ff - 1'b1;
               end
            end
            lplc_pkg::CH_RBRACE: begin
               if (brace_ff == '0) begin
                  go_tail = 1'b1;
               end else begin
                  brace_in = brace_ff - 1'b1;
               end
            end
            lplc_pkg::CH_SEMI: begin
               go_tail = 1'b1;
            end
            lplc_pkg::CH_DQUOTE, lplc_pkg::CH_SQUOTE: begin
               qdbl_in  = (ch == lplc_pkg::CH_DQUOTE);
               phase_in = PH_STR;
            end
            default: begin
            end
         endcase
      end

      // Decide mid-line; the deciding character is never blank
      if (go_tail) begin
         loose_in   = 1'b1;
         decided_in = 1'b1;
         phase_in   = PH_TAIL;
         mark_in    = pos_inc;
      end

      // Measure the tail up to its last non-blank character
      if (run_tail) begin
         pos_in = pos_inc;
         if (ch == lplc_pkg::CH_BSLASH) begin
            phase_in = PH_TAIL_BS;
            bs_cr_in = 1'b0;
         end else begin
            phase_in = PH_TAIL;
            if (!is_blank && (ch != lplc_pkg::CH_CR)) begin
               mark_in = pos_inc;
            end
         end
      end
   end

   // Hold line state, advance on each stepped character
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SKIP;
         paren_ff   <= '0;
         bracket_ff <= '0;
         brace_ff   <= '0;
         loose_ff   <= 1'b0;
         decided_ff <= 1'b0;
         qdbl_ff    <= 1'b0;
         bs_cr_ff   <= 1'b0;
         pos_ff     <= '0;
         mark_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         paren_ff   <= paren_in;
         bracket_ff <= bracket_in;
         brace_ff   <= brace_in;
         loose_ff   <= loose_in;
         decided_ff <= decided_in;
         qdbl_ff    <= qdbl_in;
         bs_cr_ff   <= bs_cr_in;
         pos_ff     <= pos_in;
         mark_ff    <= mark_in;
      end
   end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the loose pattern line classifier.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned DEPTH_TOP    = (1 << lplc_pkg::DEPTH_BITS_DEFAULT) - 1;
   localparam int unsigned COL_TOP      = (1 << lplc_pkg::LENGTH_BITS_DEFAULT) - 1;
   localparam int unsigned TOKEN_TOP    = (1 << lplc_pkg::TOKEN_BITS) - 1;
   localparam int unsigned RANDOM_CHARS = 1200;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 10;

   typedef logic [lplc_pkg::CHAR_BITS-1:0] char_type;

   typedef enum logic [2:0] {
      SCAN_SKIP, SCAN_BODY, SCAN_BODY_BS, SCAN_QUOTED,
      SCAN_QUOTE_SEEN, SCAN_TAIL, SCAN_TAIL_BS, SCAN_IGNORE
   } scan_phase_type;

   typedef struct {
      char_type    ch;
      logic        eoi;
      int unsigned gap;
      bit          hold_rsp;
   } line_char_type;

   typedef struct packed {
      logic                            emit_text;
      logic [lplc_pkg::TOKEN_BITS-1:0] token_length;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lplc_req_if req_bus ();
   lplc_rsp_if rsp_bus ();

   loose_pattern_line_classifier i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Line scanner state of the predictor
   scan_phase_type scan_phase;
   int unsigned    paren_lvl, bracket_lvl, brace_lvl;
   bit             line_loose, cut_midline, in_dquote, bs_saw_cr;
   int unsigned    line_col, last_solid;

   verdict_type    verdicts_due[$];
   line_char_type  pending[$];
   line_char_type  next_req;
   verdict_type    want;

   // Stimulus build state
   bit          gen_quiet;
   bit          gen_counts;
   int unsigned chars_counted;
   int unsigned chars_total;
   int unsigned chars_taken = 0;

   int unsigned req_gap;
   int unsigned rsp_wait;
   int unsigned hold_left;
   int unsigned lines_seen = 0;
   logic        hold_asked;
   bit          hold_done = 1'b0;
   bit          failed = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void line_clear();
      scan_phase  = SCAN_SKIP;
      paren_lvl   = 0;
      bracket_lvl = 0;
      brace_lvl   = 0;
      line_loose  = 1'b0;
      cut_midline = 1'b0;
      in_dquote   = 1'b0;
      bs_saw_cr   = 1'b0;
      line_col    = 0;
      last_solid  = 0;
   endfunction

   function automatic void advance_col();
      if (line_col < COL_TOP) line_col++;
   endfunction

   function automatic bit blank_char(input char_type c);
      return c == lplc_pkg::CH_SPACE || c == lplc_pkg::CH_TAB;
   endfunction

   // Measure the rest of a line whose verdict is already known
   function automatic void tail_take(input char_type c);
      advance_col();
      if (c == lplc_pkg::CH_BSLASH) begin
         scan_phase = SCAN_TAIL_BS;
         bs_saw_cr  = 1'b0;
      end else if (!blank_char(c) && c != lplc_pkg::CH_CR) begin
         last_solid = line_col;
      end
   endfunction

   function automatic void enter_tail(input char_type c);
      line_loose  = 1'b1;
      cut_midline = 1'b1;
      scan_phase  = SCAN_TAIL;
      tail_take(c);
   endfunction

   function automatic void body_take(input char_type c);
      scan_phase = SCAN_BODY;
      case (c)
         lplc_pkg::CH_BSLASH: begin
            advance_col();
            scan_phase = SCAN_BODY_BS;
            bs_saw_cr  = 1'b0;
         end
         lplc_pkg::CH_LPAREN: begin
            if (paren_lvl < DEPTH_TOP) paren_lvl++;
            advance_col();
         end
         lplc_pkg::CH_LBRACKET: begin
            if (bracket_lvl < DEPTH_TOP) bracket_lvl++;
            advance_col();
         end
         lplc_pkg::CH_LBRACE: begin
            if (brace_lvl < DEPTH_TOP) brace_lvl++;
            advance_col();
         end
         lplc_pkg::CH_RPAREN: begin
            if (paren_lvl == 0) enter_tail(c);
            else begin
               paren_lvl--;
               advance_col();
            end
         end
         lplc_pkg::CH_RBRACKET: begin
            if (bracket_lvl == 0) enter_tail(c);
            else begin
               bracket_lvl--;
               advance_col();
            end
         end
         lplc_pkg::CH_RBRACE: begin
            if (brace_lvl == 0) enter_tail(c);
            else begin
               brace_lvl--;
               advance_col();
            end
         end
         lplc_pkg::CH_SEMI: enter_tail(c);
         lplc_pkg::CH_DQUOTE, lplc_pkg::CH_SQUOTE: begin
            in_dquote = (c == lplc_pkg::CH_DQUOTE);
            advance_col();
            scan_phase = SCAN_QUOTED;
         end
         default: advance_col();
      endcase
   endfunction

   // Advance the line state by one request; queue a verdict at each line end
   function automatic void classify_char(input char_type c, input logic eoi);
      char_type    quote;
      logic        at_end;
      logic        emit;
      int unsigned len;
      verdict_type v;
      quote  = in_dquote ? lplc_pkg::CH_DQUOTE : lplc_pkg::CH_SQUOTE;
      at_end = eoi || c == lplc_pkg::CH_NUL;
      if (!at_end && c == lplc_pkg::CH_LF) begin
         if (scan_phase == SCAN_BODY_BS) begin
            advance_col();
            scan_phase = SCAN_BODY;
            return;
         end
         if (scan_phase == SCAN_TAIL_BS) begin
            advance_col();
            scan_phase = SCAN_TAIL;
            return;
         end
         at_end = 1'b1;
      end
      if (at_end) begin
         if (scan_phase == SCAN_TAIL_BS) last_solid = line_col;
         emit = scan_phase != SCAN_SKIP && scan_phase != SCAN_IGNORE &&
                (line_loose || paren_lvl != 0 || bracket_lvl != 0 || brace_lvl != 0);
         len = cut_midline ? last_solid : line_col;
         if (len > TOKEN_TOP) len = TOKEN_TOP;
         v.emit_text    = emit;
         v.token_length = emit ? len[lplc_pkg::TOKEN_BITS-1:0] : '0;
         verdicts_due.push_back(v);
         line_clear();
         return;
      end
      case (scan_phase)
         SCAN_SKIP: begin
            if (blank_char(c)) advance_col();
            else if (c == lplc_pkg::CH_CR) scan_phase = SCAN_IGNORE;
            else begin
               if (c == lplc_pkg::CH_COMMA || c == lplc_pkg::CH_RPAREN ||
                   c == lplc_pkg::CH_RBRACKET || c == lplc_pkg::CH_RBRACE ||
                   c == lplc_pkg::CH_SEMI) line_loose = 1'b1;
               body_take(c);
            end
         end
         SCAN_BODY: body_take(c);
         SCAN_BODY_BS, SCAN_TAIL_BS: begin
            if (!bs_saw_cr && blank_char(c)) advance_col();
            else if (!bs_saw_cr && c == lplc_pkg::CH_CR) begin
               advance_col();
               bs_saw_cr = 1'b1;
            end else if (scan_phase == SCAN_BODY_BS) body_take(c);
            else begin
               last_solid = line_col;
               scan_phase = SCAN_TAIL;
               tail_take(c);
            end
         end
         SCAN_QUOTED: begin
            if (c == quote) begin
               advance_col();
               scan_phase = SCAN_QUOTE_SEEN;
            end else if (c == lplc_pkg::CH_CR) body_take(c);
            else advance_col();
         end
         SCAN_QUOTE_SEEN: begin
            if (c == quote) begin
               advance_col();
               scan_phase = SCAN_QUOTED;
            end else body_take(c);
         end
         SCAN_TAIL: tail_take(c);
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void push_item(input char_type c, input logic eoi,
                                     input bit hold = 1'b0);
      line_char_type it;
      it.ch       = c;
      it.eoi      = eoi;
      it.gap      = gen_quiet ? 0 : $urandom_range(0, 9);
      it.hold_rsp = hold;
      pending.push_back(it);
      if (gen_counts) chars_counted++;
   endfunction

   function automatic void push_char(input char_type c);
      push_item(c, 1'b0);
   endfunction

   // End the line by newline, NUL or the end flag with a random character
   function automatic void push_line_end();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7) push_char(lplc_pkg::CH_LF);
      else if (r < 9) push_char(lplc_pkg::CH_NUL);
      else push_item(char_type'($urandom_range(0, 255)), 1'b1);
   endfunction

   function automatic char_type bracket_char(input int unsigned k, input bit closing);
      case (k)
         0: return closing ? lplc_pkg::CH_RPAREN : lplc_pkg::CH_LPAREN;
         1: return closing ? lplc_pkg::CH_RBRACKET : lplc_pkg::CH_LBRACKET;
         default: return closing ? lplc_pkg::CH_RBRACE : lplc_pkg::CH_LBRACE;
      endcase
   endfunction

   function automatic char_type word_char();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7) return char_type'(8'h61 + $urandom_range(0, 25));   // lowercase letter
      if (r < 9) return char_type'(8'h30 + $urandom_range(0, 9));    // digit
      return lplc_pkg::CH_COMMA;
   endfunction

   function automatic char_type noise_char();
      int unsigned r;
      r = $urandom_range(0, 17);
      case (r)
         0, 1, 2, 3, 4, 5: return bracket_char(r % 3, r > 2);
         6: return lplc_pkg::CH_SEMI;
         7: return lplc_pkg::CH_COMMA;
         8: return lplc_pkg::CH_DQUOTE;
         9: return lplc_pkg::CH_SQUOTE;
         10: return lplc_pkg::CH_BSLASH;
         11: return lplc_pkg::CH_SPACE;
         12: return lplc_pkg::CH_TAB;
         13: return lplc_pkg::CH_CR;
         default: return char_type'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic void push_blanks(input int unsigned n);
      repeat (n) push_char($urandom_range(0, 1) ? lplc_pkg::CH_SPACE : lplc_pkg::CH_TAB);
   endfunction

   // Mostly balanced line with strings and continuations, sometimes broken
   function automatic void gen_structured();
      char_type    closers[$];
      char_type    q;
      int unsigned k;
      push_blanks($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(0, 4);
         push_char(k < 3 ? bracket_char(k, 1'b1) :
                   (k == 3 ? lplc_pkg::CH_COMMA : lplc_pkg::CH_SEMI));
      end
      repeat ($urandom_range(1, 10)) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               k = $urandom_range(0, 2);
               push_char(bracket_char(k, 1'b0));
               closers.push_back(bracket_char(k, 1'b1));
            end
            2, 3: begin
               if (closers.size() > 0) push_char(closers.pop_back());
               else push_char(word_char());
            end
            4: begin
               q = $urandom_range(0, 1) ? lplc_pkg::CH_DQUOTE : lplc_pkg::CH_SQUOTE;
               push_char(q);
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     push_char(q);
                     push_char(q);
                  end else begin
                     k = $urandom_range(8'h20, 8'h7E);
                     push_char(k == q ? lplc_pkg::CH_SPACE : k[lplc_pkg::CHAR_BITS-1:0]);
                  end
               end
               if ($urandom_range(0, 9) != 0) push_char(q);
            end
            5: begin
               push_char(lplc_pkg::CH_BSLASH);
               push_blanks($urandom_range(0, 2));
               if ($urandom_range(0, 2) == 0) push_char(lplc_pkg::CH_CR);
               if ($urandom_range(0, 5) == 0) push_char(noise_char());
               else push_char(lplc_pkg::CH_LF);
            end
            6: push_blanks(1);
            7: begin
               if ($urandom_range(0, 1)) push_char(lplc_pkg::CH_SEMI);
               else push_char(bracket_char($urandom_range(0, 2), 1'b1));
            end
            default: repeat ($urandom_range(1, 5)) push_char(word_char());
         endcase
      end
      if ($urandom_range(0, 4) != 0)
         while (closers.size() > 0) push_char(closers.pop_back());
      push_blanks($urandom_range(0, 2));
      push_line_end();
   endfunction

   function automatic void gen_noise();
      repeat ($urandom_range(1, 16)) push_char(noise_char());
      push_line_end();
   endfunction

   function automatic void gen_raw();
      repeat ($urandom_range(1, 20)) push_char(char_type'($urandom_range(0, 255)));
      push_line_end();
   endfunction

   // A line whose first non-blank is CR: the rest is ignored by the block
   function automatic void gen_cr_first();
      push_blanks($urandom_range(0, 2));
      push_char(lplc_pkg::CH_CR);
      gen_counts = 1'b0;
      repeat ($urandom_range(0, 8)) push_char(noise_char());
      gen_counts = 1'b1;
      push_line_end();
   endfunction

   // Overfill one depth counter, then close past zero
   function automatic void gen_depth_sat(input int unsigned k);
      gen_quiet = 1'b1;
      repeat (DEPTH_TOP + 3) push_char(bracket_char(k, 1'b0));
      repeat (DEPTH_TOP + 3) push_char(bracket_char(k, 1'b1));
      push_char(lplc_pkg::CH_LF);
   endfunction

   // Back-to-back empty lines; the first one asks the receiver to hold off
   function automatic void gen_pressure();
      gen_quiet = 1'b1;
      push_item(lplc_pkg::CH_LF, 1'b0, 1'b1);
      repeat (39) push_char(lplc_pkg::CH_LF);
   endfunction

   function automatic void build_stimulus();
      bit pressed;
      gen_counts    = 1'b1;
      gen_quiet     = 1'b0;
      chars_counted = 0;
      pressed       = 1'b0;
      // directed: empty, blank-only, CR first, comma first
      push_char(lplc_pkg::CH_LF);
      push_char(lplc_pkg::CH_SPACE); push_char(lplc_pkg::CH_TAB); push_char(lplc_pkg::CH_LF);
      push_char(lplc_pkg::CH_CR); push_char(lplc_pkg::CH_RPAREN); push_char(lplc_pkg::CH_LF);
      push_char(lplc_pkg::CH_COMMA); push_char(8'h61); push_char(lplc_pkg::CH_SPACE);
      push_char(lplc_pkg::CH_LF);
      // continuation inside parens, then a stray closer, NUL end
      push_char(lplc_pkg::CH_LPAREN); push_char(lplc_pkg::CH_BSLASH);
      push_char(lplc_pkg::CH_LF);
      push_char(lplc_pkg::CH_RPAREN); push_char(lplc_pkg::CH_RBRACKET);
      push_char(lplc_pkg::CH_NUL);
      // doubled quote and an unclosed string cut by the end flag
      push_char(lplc_pkg::CH_DQUOTE); push_char(8'hFF); push_char(lplc_pkg::CH_DQUOTE);
      push_char(lplc_pkg::CH_DQUOTE);
      push_item(8'h5A, 1'b1);
      // open brace, backslash, then the end flag
      push_char(lplc_pkg::CH_LBRACE); push_char(lplc_pkg::CH_BSLASH);
      push_item(lplc_pkg::CH_LF, 1'b1);
      gen_depth_sat($urandom_range(0, 2));
      gen_counts    = 1'b1;
      chars_counted = 0;
      while (chars_counted < RANDOM_CHARS) begin
         gen_quiet = ($urandom_range(0, 3) == 0);
         if (!pressed && chars_counted >= RANDOM_CHARS / 2) begin
            gen_pressure();
            pressed   = 1'b1;
            gen_quiet = 1'b0;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gen_structured();
            12, 13, 14, 15, 16: gen_noise();
            17, 18: gen_raw();
            default: gen_cr_first();
         endcase
      end
      chars_total = pending.size();
   endfunction

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.ch           <= '0;
         req_bus.end_of_input <= 1'b0;
         req_gap = 0;
         hold_asked <= 1'b0;
         line_clear();
      end else begin
         // predict the request the block just took
         if (req_bus.valid && req_bus.ready) begin
            classify_char(req_bus.ch, req_bus.end_of_input);
            chars_taken++;
         end
         // offer the next request once the bus is free and the gap is over
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending.size() > 0) begin
               next_req = pending.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.ch           <= next_req.ch;
               req_bus.end_of_input <= next_req.eoi;
               req_gap = next_req.gap;
               if (next_req.hold_rsp) hold_asked <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- response monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait  = 0;
         hold_left = 0;
      end else begin
         // compare each response with the oldest predicted verdict
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, got emit_text %0d length %0d",
                        $time, rsp_bus.emit_text, rsp_bus.token_length);
               failed = 1'b1;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_bus.emit_text !== want.emit_text) begin
                  $display("%0t: emit_text mismatch, expected %0d, got %0d",
                           $time, want.emit_text, rsp_bus.emit_text);
                  failed = 1'b1;
               end
               if (rsp_bus.token_length !== want.token_length) begin
                  $display("%0t: token_length mismatch, expected %0d, got %0d",
                           $time, want.token_length, rsp_bus.token_length);
                  failed = 1'b1;
               end
            end
            lines_seen++;
            rsp_wait = lines_seen[4] ? 0 : $urandom_range(0, 9);
         end
         // hold off once for a long stretch, else wait the drawn cycles
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_asked && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- run control

   initial begin
      build_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (chars_taken < chars_total) @(posedge clock);
      while (verdicts_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && verdicts_due.size() == 0) begin
         $display("tb passed");
      end else begin
         if (verdicts_due.size() > 0)
            $display("%0t: %0d responses missing, expected emit_text %0d length %0d, got none",
                     $time, verdicts_due.size(), verdicts_due[0].emit_text,
                     verdicts_due[0].token_length);
         $display("tb failed");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #(2_000_000);
      $display("tb failed");
      $finish;
   end

endmodule
